FILE: sv/mhpq_pkg.sv
// Package: shared constants, types and codes for the max-heap priority queue
`default_nettype none
package mhpq_pkg;
   localparam int HEAP_DEPTH_DEF  = 128;
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int CAP_WIDTH       = 8;
   localparam int POS_WIDTH       = 7;
   localparam int OUT_WIDTH       = 32;
   localparam logic [CAP_WIDTH-1:0] CAP_RESET = 8'd100;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_DELETE = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_BADPOS = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE, S_RD_GONE, S_RD_LAST, S_WR_HOLE, S_UP_RD, S_UP_CMP,
      S_DN_RD_L, S_DN_RD_R, S_DN_CMP, S_TOP_RD, S_TOP_WAIT, S_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_RD_GONE, OP_RD_LAST, OP_WR_HOLE, OP_UP_RD, OP_UP_CMP,
      OP_DN_RD_L, OP_DN_RD_R, OP_DN_CMP, OP_TOP_RD, OP_TOP_CAP
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic reject;     // request refused or with nothing to do at load
      logic sift_up;    // hole value above the gone value
      logic sift_down;  // gone value above the hole value
      logic no_fill;    // removed the last leaf itself
      logic up_swap;    // parent compare asks for an exchange
      logic dn_swap;    // child compare asks for an exchange
      logic dn_end;     // no children within count
      logic right_ok;   // right child within count
      logic is_insert;
      logic nonempty;
   } stat_type;
endpackage
`default_nettype wire

FILE: sv/mhpq_ram.sv
// Generic single-port RAM with registered read
`default_nettype none
module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

FILE: sv/mhpq_datapath.sv
// Datapath: heap store, count, sift position and compare logic
`default_nettype none
module mhpq_datapath #(
   parameter int HEAP_DEPTH  = mhpq_pkg::HEAP_DEPTH_DEF,
   parameter int VALUE_WIDTH = mhpq_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire mhpq_pkg::cmd_type                 cmd,
   input  wire logic [1:0]                        func,
   input  wire logic [mhpq_pkg::OUT_WIDTH-1:0]    item_value,
   input  wire logic [mhpq_pkg::POS_WIDTH-1:0]    target_position,
   input  wire logic [mhpq_pkg::CAP_WIDTH-1:0]    cap_limit,
   output mhpq_pkg::stat_type                     stat,
   output logic [1:0]                             status,
   output logic [mhpq_pkg::OUT_WIDTH-1:0]         removed_value,
   output logic [mhpq_pkg::OUT_WIDTH-1:0]         top_value,
   output logic                                   top_valid,
   output logic [mhpq_pkg::CAP_WIDTH-1:0]         entry_count
);
   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int PW = (AW + 1 > mhpq_pkg::POS_WIDTH) ? AW + 1 : mhpq_pkg::POS_WIDTH;
   typedef logic [VALUE_WIDTH-1:0] val_type;

   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] pos_ff, pos_in;
   val_type       cur_ff, cur_in, gone_ff, gone_in, aux_ff, aux_in, left_ff, left_in;
   logic [1:0]    status_ff, status_in;
   logic          ins_ff, ins_in, lbig_ff, lbig_in, skip_ff, skip_in;

   logic          wr_en;
   logic [AW-1:0] addr;
   val_type       wr_data, rd_data;

   mhpq_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(HEAP_DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .addr(addr), .wr_data(wr_data), .rd_data(rd_data)
   );

   function automatic logic above(input val_type a, input val_type b);
      above = $signed(a) > $signed(b);
   endfunction

   function automatic logic [mhpq_pkg::OUT_WIDTH-1:0] to_out(input val_type v);
      to_out = mhpq_pkg::OUT_WIDTH'($signed(v));
   endfunction

   logic [CW-1:0] limit;
   logic [PW-1:0] parent, lchild, rchild, tpos;
   logic [PW:0]   lwide;
   always_comb begin
      if (CW > mhpq_pkg::CAP_WIDTH) begin
         limit = CW'(cap_limit);
      end else begin
         limit = (cap_limit > mhpq_pkg::CAP_WIDTH'(HEAP_DEPTH)) ?
                 CW'(HEAP_DEPTH) : CW'(cap_limit);
      end
      parent = (pos_ff - PW'(1)) >> 1;
      lwide  = {pos_ff, 1'b1};
      lchild = lwide[PW-1:0];
      rchild = lchild + PW'(1);
      tpos   = PW'(target_position);
   end

   logic lin, rin;
   always_comb begin
      lin = ({1'b0, lwide} < (PW+1)'(count_ff));
      rin = ((PW+1)'(lwide) + (PW+1)'(1) < (PW+1)'(count_ff));
      stat = '0;
      stat.reject    = (status_ff != mhpq_pkg::ST_OK) || skip_ff;
      stat.is_insert = ins_ff;
      stat.no_fill   = !((CW+PW)'(pos_ff) < (CW+PW)'(count_ff));
      stat.sift_up   = above(cur_ff, gone_ff);
      stat.sift_down = above(gone_ff, cur_ff);
      stat.up_swap   = (pos_ff != '0) && above(cur_ff, rd_data);
      stat.dn_end    = !lin;
      stat.right_ok  = rin;
      stat.dn_swap   = lbig_ff ? above(left_ff, cur_ff) || (rin && above(rd_data, cur_ff))
                               : (rin && above(rd_data, cur_ff));
      stat.nonempty  = (count_ff != '0);
   end

   // right child beats left only if strictly greater
   logic use_right;
   always_comb begin
      use_right = rin && (lbig_ff ? above(rd_data, left_ff) : above(rd_data, cur_ff));
   end

   always_comb begin
      count_in = count_ff; pos_in = pos_ff;
      cur_in = cur_ff; gone_in = gone_ff; aux_in = aux_ff; left_in = left_ff;
      status_in = status_ff; ins_in = ins_ff; lbig_in = lbig_ff; skip_in = skip_ff;
      wr_en = 1'b0; addr = pos_ff[AW-1:0]; wr_data = cur_ff;
      case (cmd.op)
         mhpq_pkg::OP_LOAD: begin
            status_in = mhpq_pkg::ST_OK;
            ins_in    = 1'b0;
            skip_in   = 1'b0;
            gone_in   = '0;
            aux_in    = '0;
            case (func)
               mhpq_pkg::FUNC_INSERT: begin
                  ins_in = 1'b1;
                  if (count_ff >= limit) begin
                     status_in = mhpq_pkg::ST_FULL;
                  end else begin
                     cur_in   = VALUE_WIDTH'($signed(item_value));
                     pos_in   = PW'(count_ff);
                     count_in = count_ff + CW'(1);
                  end
               end
               mhpq_pkg::FUNC_REMOVE: begin
                  if (count_ff == '0) status_in = mhpq_pkg::ST_EMPTY;
                  else pos_in = '0;
               end
               mhpq_pkg::FUNC_DELETE: begin
                  if (count_ff == '0) status_in = mhpq_pkg::ST_EMPTY;
                  else if ((CW+PW)'(tpos) >= (CW+PW)'(count_ff)) status_in = mhpq_pkg::ST_BADPOS;
                  else pos_in = tpos;
               end
               default: skip_in = 1'b1;
            endcase
         end
         mhpq_pkg::OP_RD_GONE: addr = pos_ff[AW-1:0];
         mhpq_pkg::OP_RD_LAST: begin
            gone_in  = rd_data;
            aux_in   = rd_data;
            addr     = AW'(count_ff - CW'(1));
            count_in = count_ff - CW'(1);
         end
         mhpq_pkg::OP_WR_HOLE: begin
            cur_in = rd_data;
            if ((CW+PW)'(pos_ff) < (CW+PW)'(count_ff)) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
            end
         end
         mhpq_pkg::OP_UP_RD: begin
            if (pos_ff != '0) addr = parent[AW-1:0];
            else wr_data = cur_ff;
            wr_en = (pos_ff == '0) || ins_ff && 1'b0;
            if (pos_ff == '0) wr_en = 1'b1;
            if (ins_ff && pos_ff != '0) begin
               wr_en = 1'b0;
            end
         end
         mhpq_pkg::OP_UP_CMP: begin
            // write the item at its final slot, or move the parent down into it on a swap
            wr_en = 1'b1;
            if (stat.up_swap) begin
               wr_data = rd_data;
               pos_in  = parent;
            end
         end
         mhpq_pkg::OP_DN_RD_L: begin
            // a leaf takes the sinking value
            if (stat.dn_end) wr_en = 1'b1;
            else addr = lchild[AW-1:0];
         end
         mhpq_pkg::OP_DN_RD_R: begin
            left_in = rd_data;
            lbig_in = above(rd_data, cur_ff);
            addr    = rchild[AW-1:0];
         end
         mhpq_pkg::OP_DN_CMP: begin
            wr_en = 1'b1;
            if (stat.dn_swap) begin
               wr_data = use_right ? rd_data : left_ff;
               pos_in  = use_right ? rchild : lchild;
            end
         end
         mhpq_pkg::OP_TOP_RD: addr = '0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      pos_ff <= pos_in; cur_ff <= cur_in; gone_ff <= gone_in;
      aux_ff <= aux_in; left_ff <= left_in; status_ff <= status_in; ins_ff <= ins_in;
      lbig_ff <= lbig_in; skip_ff <= skip_in;
   end

   always_comb begin
      status        = status_ff;
      removed_value = to_out(aux_ff);
      top_valid     = (count_ff != '0);
      top_value     = top_valid ? to_out(rd_data) : '0;
      entry_count   = mhpq_pkg::CAP_WIDTH'(count_ff);
   end
endmodule
`default_nettype wire

FILE: sv/mhpq_ctrl.sv
// Controller: sequences load, fill, sift and top read for one request
`default_nettype none
module mhpq_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire mhpq_pkg::stat_type stat,
   output mhpq_pkg::cmd_type       cmd,
   output logic                    busy,
   output logic                    done
);
   mhpq_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mhpq_pkg::S_IDLE:    if (start) state_in = mhpq_pkg::S_RD_GONE;
         mhpq_pkg::S_RD_GONE: begin
            if (stat.reject) state_in = mhpq_pkg::S_TOP_RD;
            else if (stat.is_insert) state_in = mhpq_pkg::S_UP_RD;
            else state_in = mhpq_pkg::S_RD_LAST;
         end
         mhpq_pkg::S_RD_LAST: state_in = mhpq_pkg::S_WR_HOLE;
         mhpq_pkg::S_WR_HOLE: begin
            if (stat.no_fill) state_in = mhpq_pkg::S_TOP_RD;
            else state_in = mhpq_pkg::S_TOP_WAIT;
         end
         mhpq_pkg::S_TOP_WAIT: begin
            if (stat.sift_up) state_in = mhpq_pkg::S_UP_RD;
            else if (stat.sift_down) state_in = mhpq_pkg::S_DN_RD_L;
            else state_in = mhpq_pkg::S_TOP_RD;
         end
         mhpq_pkg::S_UP_RD:   state_in = mhpq_pkg::S_UP_CMP;
         mhpq_pkg::S_UP_CMP:  state_in = stat.up_swap ? mhpq_pkg::S_UP_RD : mhpq_pkg::S_TOP_RD;
         mhpq_pkg::S_DN_RD_L: state_in = stat.dn_end ? mhpq_pkg::S_TOP_RD : mhpq_pkg::S_DN_RD_R;
         mhpq_pkg::S_DN_RD_R: state_in = mhpq_pkg::S_DN_CMP;
         mhpq_pkg::S_DN_CMP:  state_in = stat.dn_swap ? mhpq_pkg::S_DN_RD_L : mhpq_pkg::S_TOP_RD;
         mhpq_pkg::S_TOP_RD:  state_in = mhpq_pkg::S_DONE;
         mhpq_pkg::S_DONE:    state_in = mhpq_pkg::S_IDLE;
         default:             state_in = mhpq_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op = mhpq_pkg::OP_NONE;
      busy   = (state_ff != mhpq_pkg::S_IDLE);
      done   = 1'b0;
      case (state_ff)
         mhpq_pkg::S_IDLE:     if (start) cmd.op = mhpq_pkg::OP_LOAD;
         mhpq_pkg::S_RD_GONE:  cmd.op = stat.is_insert ? mhpq_pkg::OP_NONE : mhpq_pkg::OP_RD_GONE;
         mhpq_pkg::S_RD_LAST:  cmd.op = mhpq_pkg::OP_RD_LAST;
         mhpq_pkg::S_WR_HOLE:  cmd.op = mhpq_pkg::OP_WR_HOLE;
         mhpq_pkg::S_UP_RD:    cmd.op = mhpq_pkg::OP_UP_RD;
         mhpq_pkg::S_UP_CMP:   cmd.op = mhpq_pkg::OP_UP_CMP;
         mhpq_pkg::S_DN_RD_L:  cmd.op = mhpq_pkg::OP_DN_RD_L;
         mhpq_pkg::S_DN_RD_R:  cmd.op = mhpq_pkg::OP_DN_RD_R;
         mhpq_pkg::S_DN_CMP:   cmd.op = mhpq_pkg::OP_DN_CMP;
         mhpq_pkg::S_TOP_RD:   cmd.op = mhpq_pkg::OP_TOP_RD;
         mhpq_pkg::S_DONE: begin
            cmd.op = mhpq_pkg::OP_TOP_CAP;
            done   = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mhpq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

FILE: sv/max_heap_priority_queue_core.sv
// Top level: binary max-heap priority queue core
// Refused or unused words go straight to the top read; an insert climbs level by level;
// remove/delete fills the hole from the last leaf, unless it was that leaf, then climbs or sinks.
// One word in flight; the next start is taken after the result.
// Result word shows on rsp_ ports for one cycle with rsp_valid; the receiver cannot stall.
// Reset: synchronous, active high; empties the heap and sets capacity_limit to 100.
`default_nettype none
module max_heap_priority_queue_core #(
   parameter int HEAP_DEPTH  = mhpq_pkg::HEAP_DEPTH_DEF,
   parameter int VALUE_WIDTH = mhpq_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [1:0]                         req_func,
   input  wire logic [mhpq_pkg::OUT_WIDTH-1:0]     req_item_value,
   input  wire logic [mhpq_pkg::POS_WIDTH-1:0]     req_target_position,
   output logic                                    rsp_valid,
   output logic [1:0]                              rsp_status,
   output logic [mhpq_pkg::OUT_WIDTH-1:0]          rsp_removed_value,
   output logic [mhpq_pkg::OUT_WIDTH-1:0]          rsp_top_value,
   output logic                                    rsp_top_valid,
   output logic [mhpq_pkg::CAP_WIDTH-1:0]          rsp_entry_count,
   input  wire logic                               csr_we,
   input  wire logic [mhpq_pkg::CAP_WIDTH-1:0]     csr_wdata
);
   logic [mhpq_pkg::CAP_WIDTH-1:0] cap_ff;
   mhpq_pkg::cmd_type  cmd;
   mhpq_pkg::stat_type stat;
   logic done;
   logic [mhpq_pkg::OUT_WIDTH-1:0] top_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= mhpq_pkg::CAP_RESET;
      end else if (csr_we) begin
         cap_ff <= csr_wdata;
      end
   end

   mhpq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .stat(stat),
      .cmd(cmd), .busy(busy), .done(done)
   );

   mhpq_datapath #(.HEAP_DEPTH(HEAP_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .func(req_func),
      .item_value(req_item_value), .target_position(req_target_position),
      .cap_limit(cap_ff), .stat(stat), .status(rsp_status),
      .removed_value(rsp_removed_value), .top_value(top_v),
      .top_valid(rsp_top_valid), .entry_count(rsp_entry_count)
   );

   always_comb begin
      rsp_valid     = done;
      rsp_top_value = top_v;
   end
endmodule
`default_nettype wire

FILE: sv/mhpq_checker.sv
// Port checker for the max-heap priority queue core, bound to the top level
`default_nettype none
module mhpq_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_top_valid,
   input wire logic [7:0] rsp_entry_count
);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted word did not raise busy");
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside busy");
   a_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy held after result");
   a_topvalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_top_valid == (rsp_entry_count != 8'd0)))
      else $error("top_valid disagrees with count");
   a_badpos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mhpq_pkg::ST_BADPOS |-> rsp_entry_count != 8'd0)
      else $error("bad position reported on empty heap");
endmodule

bind max_heap_priority_queue_core mhpq_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_status(rsp_status), .rsp_top_valid(rsp_top_valid),
   .rsp_entry_count(rsp_entry_count)
);
`default_nettype wire

FILE: bench/max_heap_priority_queue_core_test.sv
// Testbench for the max-heap priority queue core: random and directed words checked against a heap model
`default_nettype none
class heap_scoreboard;
   typedef struct {
      logic [1:0]  status;
      logic [31:0] removed;
      logic [31:0] top;
      logic        top_valid;
      logic [7:0]  count;
   } heap_word_type;

   logic signed [31:0] heap_mem [128];
   int unsigned        heap_count;
   int unsigned        cap_limit;
   heap_word_type      pending_words [$];
   int                 mismatches;

   function new();
      heap_count = 0;
      cap_limit  = 100;
      mismatches = 0;
   endfunction

   function void swap_at(int unsigned i, int unsigned j);
      logic signed [31:0] t;
      t = heap_mem[i];
      heap_mem[i] = heap_mem[j];
      heap_mem[j] = t;
   endfunction

   function void sift_up(int unsigned pos);
      int unsigned parent;
      while (pos != 0) begin
         parent = (pos - 1) / 2;
         if (!(heap_mem[pos] > heap_mem[parent])) break;
         swap_at(pos, parent);
         pos = parent;
      end
   endfunction

   function void sift_down(int unsigned pos);
      int unsigned l, r, best;
      while (pos < heap_count) begin
         l = 2 * pos + 1;
         r = 2 * pos + 2;
         best = pos;
         if (l < heap_count && heap_mem[l] > heap_mem[best]) best = l;
         if (r < heap_count && heap_mem[r] > heap_mem[best]) best = r;
         if (best == pos) break;
         swap_at(pos, best);
         pos = best;
      end
   endfunction

   function logic [31:0] extract_at(int unsigned pos);
      logic signed [31:0] gone, last;
      gone = heap_mem[pos];
      last = heap_mem[heap_count - 1];
      heap_count--;
      if (pos < heap_count) begin
         heap_mem[pos] = last;
         if (last > gone) sift_up(pos);
         else if (gone > last) sift_down(pos);
      end
      return gone;
   endfunction

   function void note_request(logic [1:0] func, logic [31:0] value, logic [6:0] pos);
      heap_word_type w;
      int unsigned lim;
      w.status  = mhpq_pkg::ST_OK;
      w.removed = '0;
      lim = (cap_limit < 128) ? cap_limit : 128;
      case (func)
         mhpq_pkg::FUNC_INSERT: begin
            if (heap_count >= lim) w.status = mhpq_pkg::ST_FULL;
            else begin
               heap_mem[heap_count] = value;
               heap_count++;
               sift_up(heap_count - 1);
            end
         end
         mhpq_pkg::FUNC_REMOVE: begin
            if (heap_count == 0) w.status = mhpq_pkg::ST_EMPTY;
            else w.removed = extract_at(0);
         end
         mhpq_pkg::FUNC_DELETE: begin
            if (heap_count == 0) w.status = mhpq_pkg::ST_EMPTY;
            else if (pos >= heap_count) w.status = mhpq_pkg::ST_BADPOS;
            else w.removed = extract_at(pos);
         end
         default: ;
      endcase
      w.top       = heap_count != 0 ? heap_mem[0] : '0;
      w.top_valid = heap_count != 0;
      w.count     = heap_count[7:0];
      pending_words.push_back(w);
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      mismatches++;
   endtask

   task check_word(logic [1:0] st, logic [31:0] rem, logic [31:0] top,
                   logic tv, logic [7:0] cnt);
      heap_word_type w;
      if (pending_words.size() == 0) begin
         report("unexpected word", 0, 0);
         return;
      end
      w = pending_words.pop_front();
      if (st !== w.status) report("status", st, w.status);
      if (rem !== w.removed) report("removed_value", rem, w.removed);
      if (top !== w.top) report("top_value", top, w.top);
      if (tv !== w.top_valid) report("top_valid", tv, w.top_valid);
      if (cnt !== w.count) report("entry_count", cnt, w.count);
   endtask
endclass

module max_heap_priority_queue_core_test;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_func = mhpq_pkg::FUNC_INSERT;
   logic [31:0] req_item_value = '0;
   logic [6:0]  req_target_position = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_removed_value;
   logic [31:0] rsp_top_value;
   logic        rsp_top_valid;
   logic [7:0]  rsp_entry_count;
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = '0;

   heap_scoreboard heap_sb = new();
   int burst_left = 0;

   max_heap_priority_queue_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_item_value(req_item_value),
      .req_target_position(req_target_position),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_removed_value(rsp_removed_value), .rsp_top_value(rsp_top_value),
      .rsp_top_valid(rsp_top_valid), .rsp_entry_count(rsp_entry_count),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         heap_sb.check_word(rsp_status, rsp_removed_value, rsp_top_value,
                            rsp_top_valid, rsp_entry_count);
   end

   // one word; start held until accepted, idle gaps between bursts
   task automatic send_word(logic [1:0] func, logic [31:0] value, logic [6:0] pos);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0)
            repeat ($urandom_range(1, 20)) @(posedge clock);
      end
      burst_left--;
      start <= 1'b1;
      req_func <= func;
      req_item_value <= value;
      req_target_position <= pos;
      do @(posedge clock); while (busy);
      heap_sb.note_request(func, value, pos);
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (heap_sb.pending_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_cap(logic [7:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      heap_sb.cap_limit = v;
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 15) - 8;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_phase(int n, int ins_weight);
      int k;
      logic [1:0] f;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         if (k < ins_weight) f = mhpq_pkg::FUNC_INSERT;
         else if (k < ins_weight + (100 - ins_weight) / 2) f = mhpq_pkg::FUNC_REMOVE;
         else if (k < 98) f = mhpq_pkg::FUNC_DELETE;
         else f = mhpq_pkg::FUNC_UNUSED;
         send_word(f, rand_value(),
                   (heap_sb.heap_count > 0 && $urandom_range(0, 7) != 0) ?
                      7'($urandom_range(0, heap_sb.heap_count - 1)) : 7'($urandom));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // empty-heap refusals, unused op, extremes
      send_word(mhpq_pkg::FUNC_REMOVE, 32'h0, 7'd0);
      send_word(mhpq_pkg::FUNC_DELETE, 32'h0, 7'd127);
      send_word(mhpq_pkg::FUNC_UNUSED, 32'hffff_ffff, 7'd127);
      send_word(mhpq_pkg::FUNC_INSERT, 32'h8000_0000, 7'd0);
      send_word(mhpq_pkg::FUNC_INSERT, 32'h7fff_ffff, 7'd0);
      send_word(mhpq_pkg::FUNC_INSERT, 32'h0, 7'd0);
      send_word(mhpq_pkg::FUNC_INSERT, 32'hffff_ffff, 7'd0);
      send_word(mhpq_pkg::FUNC_INSERT, 32'h5555_aaaa, 7'd0);
      send_word(mhpq_pkg::FUNC_DELETE, 32'h0, 7'd5);
      send_word(mhpq_pkg::FUNC_DELETE, 32'h0, 7'd127);
      send_word(mhpq_pkg::FUNC_DELETE, 32'h0, 7'd4);
      send_word(mhpq_pkg::FUNC_DELETE, 32'h0, 7'd1);
      send_word(mhpq_pkg::FUNC_REMOVE, 32'h0, 7'd0);
      send_word(mhpq_pkg::FUNC_INSERT, 32'haaaa_5555, 7'd0);
      // full heap at a tiny limit
      write_cap(8'd1);
      send_word(mhpq_pkg::FUNC_INSERT, 32'h1, 7'd0);
      send_word(mhpq_pkg::FUNC_INSERT, 32'h2, 7'd0);
      send_word(mhpq_pkg::FUNC_REMOVE, 32'h0, 7'd0);
      send_word(mhpq_pkg::FUNC_REMOVE, 32'h0, 7'd0);
      send_word(mhpq_pkg::FUNC_REMOVE, 32'h0, 7'd0);
      write_cap(8'd0);
      send_word(mhpq_pkg::FUNC_INSERT, 32'h3, 7'd0);
      write_cap(8'd5);
      random_phase(60, 60);
      write_cap(8'd255);
      random_phase(170, 85);
      random_phase(80, 40);
      write_cap(8'd128);
      random_phase(90, 70);
      write_cap(8'd100);
      random_phase(40, 30);
      drain();
      if (heap_sb.mismatches == 0 && heap_sb.pending_words.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire

FILE: max_heap_priority_queue_core.f
sv/mhpq_pkg.sv
sv/mhpq_ram.sv
sv/mhpq_datapath.sv
sv/mhpq_ctrl.sv
sv/max_heap_priority_queue_core.sv
sv/mhpq_checker.sv
bench/max_heap_priority_queue_core_test.sv
